### hw/rtl/okl_pkg.sv
`timescale 1ns / 1ps

package okl_pkg;

    localparam int CAPACITY    = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int KEY_W       = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 2;
    localparam int POS_W       = 4;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INS_ORD   = 3'd0,
        OP_INS_FRONT = 3'd1,
        OP_INS_END   = 3'd2,
        OP_DEL_KEY   = 3'd3,
        OP_DEL_FRONT = 3'd4,
        OP_FIND      = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } cmd_t;

    // Report an index modulo the width of the position field.
    function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
        logic [IDX_W+POS_W-1:0] wide;
        wide = {{POS_W{1'b0}}, idx};
        return wide[POS_W-1:0];
    endfunction

    // Report a count modulo the width of the count field.
    function automatic logic [COUNT_OUT_W-1:0] to_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+COUNT_OUT_W-1:0] wide;
        wide = {{COUNT_OUT_W{1'b0}}, cnt};
        return wide[COUNT_OUT_W-1:0];
    endfunction

endpackage

### hw/rtl/okl_ifs.sv
`timescale 1ns / 1ps

interface okl_req_if;
    logic                                valid;
    logic                                ready;
    logic [okl_pkg::OP_W-1:0]            operation;
    logic signed [okl_pkg::KEY_W-1:0]    key_value;

    modport source (output valid, output operation, output key_value, input ready);
    modport sink   (input valid, input operation, input key_value, output ready);
endinterface

interface okl_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [okl_pkg::STATUS_W-1:0]        status;
    logic [okl_pkg::POS_W-1:0]           position;
    logic [okl_pkg::COUNT_OUT_W-1:0]     entry_count;
    logic signed [okl_pkg::KEY_W-1:0]    front_key;

    modport source (output valid, output status, output position, output entry_count,
                    output front_key, input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    input front_key, output ready);
endinterface

### hw/rtl/okl_ctrl.sv
`timescale 1ns / 1ps

module okl_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output okl_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    assign req_ready   = (state_reg == S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign cmd.capture = req_valid && req_ready;
    // Execute only once the result register is free or being emptied.
    assign cmd.execute = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = cmd.capture ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = cmd.execute ? S_IDLE : S_EXEC;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.execute)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_no_capture_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.capture && cmd.execute))
        else $error("capture and execute in the same cycle");

endmodule

### hw/rtl/okl_datapath.sv
`timescale 1ns / 1ps

module okl_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  okl_pkg::cmd_t                       cmd,
    input  logic [okl_pkg::OP_W-1:0]            operation,
    input  logic signed [okl_pkg::KEY_W-1:0]    key_value,
    output logic [okl_pkg::STATUS_W-1:0]        status,
    output logic [okl_pkg::POS_W-1:0]           position,
    output logic [okl_pkg::COUNT_OUT_W-1:0]     entry_count,
    output logic signed [okl_pkg::KEY_W-1:0]    front_key
);

    okl_pkg::op_t                         op_reg;
    logic signed [okl_pkg::KEY_W-1:0]     key_reg;
    logic signed [okl_pkg::KEY_W-1:0]     slot_reg  [okl_pkg::CAPACITY];
    logic signed [okl_pkg::KEY_W-1:0]     slot_next [okl_pkg::CAPACITY];
    logic [okl_pkg::CNT_W-1:0]            count_reg;
    logic [okl_pkg::CNT_W-1:0]            count_next;

    logic [okl_pkg::STATUS_W-1:0]         status_reg;
    logic [okl_pkg::POS_W-1:0]            position_reg;
    logic [okl_pkg::COUNT_OUT_W-1:0]      entry_count_reg;
    logic signed [okl_pkg::KEY_W-1:0]     front_key_reg;

    logic [okl_pkg::CAPACITY-1:0]         gt_vec;
    logic [okl_pkg::CAPACITY-1:0]         eq_vec;
    logic [okl_pkg::IDX_W-1:0]            gt_pos;
    logic [okl_pkg::IDX_W-1:0]            eq_pos;
    logic                                 is_full;
    logic                                 is_empty;
    logic                                 do_ins;
    logic                                 do_del;
    logic [okl_pkg::IDX_W-1:0]            at_idx;
    okl_pkg::status_t                     status_next;
    logic [okl_pkg::IDX_W-1:0]            pos_next;

    assign status      = status_reg;
    assign position    = position_reg;
    assign entry_count = entry_count_reg;
    assign front_key   = front_key_reg;

    assign is_full  = (count_reg == okl_pkg::CNT_W'(okl_pkg::CAPACITY));
    assign is_empty = (count_reg == '0);

    // Compare every occupied cell against the key in parallel.
    always_comb
    begin
        for (int i = 0; i < okl_pkg::CAPACITY; i++)
        begin
            gt_vec[i] = (okl_pkg::CNT_W'(i) < count_reg) && (slot_reg[i] > key_reg);
            eq_vec[i] = (okl_pkg::CNT_W'(i) < count_reg) && (slot_reg[i] == key_reg);
        end
    end

    // First cell from the front wins; insert at the end when none is greater.
    always_comb
    begin
        gt_pos = count_reg[okl_pkg::IDX_W-1:0];
        eq_pos = '0;
        for (int i = okl_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (gt_vec[i])
            begin
                gt_pos = okl_pkg::IDX_W'(i);
            end
            if (eq_vec[i])
            begin
                eq_pos = okl_pkg::IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        do_ins      = 1'b0;
        do_del      = 1'b0;
        at_idx      = '0;
        status_next = okl_pkg::ST_OK;
        pos_next    = '0;
        case (op_reg)
            okl_pkg::OP_INS_ORD, okl_pkg::OP_INS_FRONT, okl_pkg::OP_INS_END:
            begin
                if (is_full)
                begin
                    status_next = okl_pkg::ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                    if (op_reg == okl_pkg::OP_INS_ORD)
                    begin
                        at_idx = gt_pos;
                    end
                    else if (op_reg == okl_pkg::OP_INS_END)
                    begin
                        at_idx = count_reg[okl_pkg::IDX_W-1:0];
                    end
                    pos_next = at_idx;
                end
            end
            okl_pkg::OP_DEL_KEY, okl_pkg::OP_FIND:
            begin
                if (is_empty)
                begin
                    status_next = okl_pkg::ST_EMPTY;
                end
                else if (eq_vec == '0)
                begin
                    status_next = okl_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    pos_next = eq_pos;
                    at_idx   = eq_pos;
                    do_del   = (op_reg == okl_pkg::OP_DEL_KEY);
                end
            end
            okl_pkg::OP_DEL_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = okl_pkg::ST_EMPTY;
                end
                else
                begin
                    do_del = 1'b1;
                end
            end
            default:
            begin
                status_next = okl_pkg::ST_OK;
            end
        endcase
    end

    // Shift cells towards the back to open a gap, or towards the front to close one.
    always_comb
    begin
        for (int i = 0; i < okl_pkg::CAPACITY; i++)
        begin
            slot_next[i] = slot_reg[i];
        end
        if (do_ins)
        begin
            if (at_idx == '0)
            begin
                slot_next[0] = key_reg;
            end
            for (int i = 1; i < okl_pkg::CAPACITY; i++)
            begin
                if (okl_pkg::IDX_W'(i) == at_idx)
                begin
                    slot_next[i] = key_reg;
                end
                else if (okl_pkg::IDX_W'(i) > at_idx)
                begin
                    slot_next[i] = slot_reg[i-1];
                end
            end
        end
        else if (do_del)
        begin
            for (int i = 0; i < okl_pkg::CAPACITY - 1; i++)
            begin
                if (okl_pkg::IDX_W'(i) >= at_idx)
                begin
                    slot_next[i] = slot_reg[i+1];
                end
            end
        end
    end

    always_comb
    begin
        if (do_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_del)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= okl_pkg::op_t'(operation);
            key_reg <= key_value;
        end
        if (cmd.execute)
        begin
            for (int i = 0; i < okl_pkg::CAPACITY; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
            status_reg      <= status_next;
            position_reg    <= okl_pkg::to_pos(pos_next);
            entry_count_reg <= okl_pkg::to_count(count_next);
            front_key_reg   <= (count_next == '0) ? '0 : slot_next[0];
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= okl_pkg::CNT_W'(okl_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    a_count_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.execute |=> $stable(count_reg))
        else $error("entry count moved without an operation");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && do_ins) |=> (count_reg == okl_pkg::CNT_W'($past(count_reg) + 1'b1)))
        else $error("accepted insert did not grow the list by one");

    a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.execute && (status_next == okl_pkg::ST_FULL || status_next == okl_pkg::ST_EMPTY
                         || status_next == okl_pkg::ST_NOT_FOUND))
        |=> $stable(count_reg))
        else $error("refused operation changed the list");

endmodule

### hw/rtl/ordered_key_list.sv
`timescale 1ns / 1ps

// Ordered list of up to okl_pkg::CAPACITY signed 32-bit keys, held front to back in a
// row of register cells. Each request word carries one operation (insert in order,
// insert at front, insert at end, delete first equal key, delete front, find) and
// yields exactly one response word with status, position, count and front key. A
// request is first registered, then executed: every occupied cell is compared with
// the key in parallel and the cells shift by one place to open or close a gap. A new
// request is taken only after the previous one has executed; one finished response
// may wait in the output register while the next request is taken, and execution
// then holds until that response leaves.
module ordered_key_list
(
    input  logic         clk,
    input  logic         rst_n,
    okl_req_if.sink      req,
    okl_rsp_if.source    rsp
);

    okl_pkg::cmd_t cmd;

    okl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    okl_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (req.operation),
        .key_value   (req.key_value),
        .status      (rsp.status),
        .position    (rsp.position),
        .entry_count (rsp.entry_count),
        .front_key   (rsp.front_key)
    );

endmodule

### dv/ordered_key_list_tb.sv
`timescale 1ns / 1ps

module ordered_key_list_tb;

    import okl_pkg::*;

    // Operation codes the block does not define; it must leave the list alone.
    localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd7;

    localparam int PHASE_ITEMS = 600;
    localparam int HOLD_OFF_CYCLES = 90;

    typedef enum int { MODE_FILL, MODE_EMPTY_OUT, MODE_MIXED } traffic_mode_t;

    typedef struct {
        status_t                  status;
        logic [POS_W-1:0]         position;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic signed [KEY_W-1:0]  front_key;
    } list_result_t;

    class key_list_shadow;
        logic signed [KEY_W-1:0] held_keys[$];
        list_result_t            awaited_results[$];
        int unsigned             mismatches;
        int unsigned             requests_seen;
        int unsigned             results_seen;
        int unsigned             status_seen[4];

        // Apply one request word to the shadow list and queue the response it gives.
        function void note_request(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
            list_result_t res;
            int unsigned  slot;
            bit           hit;
            res.status   = ST_OK;
            res.position = '0;
            slot = 0;
            hit  = 1'b0;
            requests_seen++;
            case (op)
                OP_INS_ORD, OP_INS_FRONT, OP_INS_END:
                begin
                    if (held_keys.size() >= CAPACITY)
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        if (op != OP_INS_FRONT)
                        begin
                            slot = held_keys.size();
                        end
                        // Go in front of the first greater key, scanning from the front.
                        if (op == OP_INS_ORD)
                        begin
                            foreach (held_keys[i])
                            begin
                                if (!hit && held_keys[i] > key)
                                begin
                                    slot = i;
                                    hit  = 1'b1;
                                end
                            end
                        end
                        held_keys.insert(slot, key);
                        res.position = POS_W'(slot);
                    end
                end
                OP_DEL_KEY, OP_FIND:
                begin
                    if (held_keys.size() == 0)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        foreach (held_keys[i])
                        begin
                            if (!hit && held_keys[i] == key)
                            begin
                                slot = i;
                                hit  = 1'b1;
                            end
                        end
                        if (!hit)
                        begin
                            res.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            res.position = POS_W'(slot);
                            if (op == OP_DEL_KEY)
                            begin
                                held_keys.delete(slot);
                            end
                        end
                    end
                end
                OP_DEL_FRONT:
                begin
                    if (held_keys.size() == 0)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else
                    begin
                        held_keys.delete(0);
                    end
                end
                default:
                begin
                end
            endcase
            res.entry_count = COUNT_OUT_W'(held_keys.size());
            res.front_key   = (held_keys.size() != 0) ? held_keys[0] : '0;
            awaited_results.push_back(res);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [POS_W-1:0] position,
                                   logic [COUNT_OUT_W-1:0] entry_count,
                                   logic signed [KEY_W-1:0] front_key);
            list_result_t exp;
            results_seen++;
            if (awaited_results.size() == 0)
            begin
                $error("response word with no request outstanding");
                mismatches++;
                return;
            end
            exp = awaited_results.pop_front();
            status_seen[exp.status]++;
            if (status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, status);
                mismatches++;
            end
            if (position !== exp.position)
            begin
                $error("position: expected %0d, got %0d", exp.position, position);
                mismatches++;
            end
            if (entry_count !== exp.entry_count)
            begin
                $error("entry_count: expected %0d, got %0d", exp.entry_count, entry_count);
                mismatches++;
            end
            if (front_key !== exp.front_key)
            begin
                $error("front_key: expected %0d, got %0d", exp.front_key, front_key);
                mismatches++;
            end
        endfunction

        function logic signed [KEY_W-1:0] pick_held_key();
            if (held_keys.size() == 0)
            begin
                return $urandom;
            end
            return held_keys[$urandom_range(held_keys.size() - 1)];
        endfunction
    endclass

    logic clk;
    logic rst_n;

    okl_req_if req_if ();
    okl_rsp_if rsp_if ();

    key_list_shadow shadow = new();

    int unsigned tx_idle_pct;
    int unsigned rx_stall_pct;
    bit          hold_off_request;
    int unsigned items_sent;
    int unsigned hold_offs_done;

    ordered_key_list i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Response side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            shadow.check_result(rsp_if.status, rsp_if.position, rsp_if.entry_count,
                                rsp_if.front_key);
        end
    end

    // Offer one request word and hold it until taken.
    task automatic send_request(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key);
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.key_value <= key;
        do
            @(posedge clk);
        while (!req_if.ready);
        shadow.note_request(op, key);
        items_sent++;
    endtask

    task automatic maybe_idle_sender();
        if ($urandom_range(99) < tx_idle_pct)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Stop offering and wait until every response has come back.
    task automatic wait_all_returned();
        req_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (shadow.awaited_results.size() != 0);
    endtask

    function automatic logic signed [KEY_W-1:0] random_key();
        logic signed [KEY_W-1:0] key;
        int unsigned             pick;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            key = KEY_W'($urandom_range(16)) - KEY_W'(8);
        end
        else if (pick < 65)
        begin
            key = shadow.pick_held_key();
        end
        else if (pick < 75)
        begin
            case ($urandom_range(3))
                0: key = {1'b1, {(KEY_W-1){1'b0}}};
                1: key = {1'b0, {(KEY_W-1){1'b1}}};
                2: key = '1;
                default: key = '0;
            endcase
        end
        else
        begin
            key = $urandom;
        end
        return key;
    endfunction

    function automatic logic [OP_W-1:0] random_op(traffic_mode_t mode);
        int unsigned pick;
        pick = $urandom_range(99);
        case (mode)
            MODE_FILL:
            begin
                if (pick < 50)      return OP_INS_ORD;
                else if (pick < 62) return OP_INS_FRONT;
                else if (pick < 75) return OP_INS_END;
                else if (pick < 90) return OP_FIND;
                else if (pick < 95) return OP_DEL_KEY;
                else                return OP_DEL_FRONT;
            end
            MODE_EMPTY_OUT:
            begin
                if (pick < 35)      return OP_DEL_KEY;
                else if (pick < 65) return OP_DEL_FRONT;
                else if (pick < 85) return OP_FIND;
                else                return OP_INS_ORD;
            end
            default:
            begin
                if (pick < 4)       return OP_UNUSED_A;
                else if (pick < 8)  return OP_UNUSED_B;
                else                return OP_W'($urandom_range(OP_FIND));
            end
        endcase
    endfunction

    task automatic run_phase(int unsigned tx_pct, int unsigned rx_pct, bit with_hold_off);
        int unsigned   sent;
        int unsigned   run_len;
        traffic_mode_t mode;
        bit            quiet;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            mode    = traffic_mode_t'($urandom_range(MODE_MIXED));
            run_len = $urandom_range(10, 40);
            quiet   = ($urandom_range(5) == 0);
            tx_idle_pct  = quiet ? 0 : tx_pct;
            rx_stall_pct = quiet ? 0 : rx_pct;
            if (with_hold_off && sent >= PHASE_ITEMS / 2 && hold_offs_done == 0)
            begin
                // Keep offering back to back while the response side stays blocked.
                hold_off_request = 1'b1;
                hold_offs_done++;
                tx_idle_pct = 0;
                run_len = 40;
            end
            repeat (run_len)
            begin
                send_request(random_op(mode), random_key());
                maybe_idle_sender();
                sent++;
            end
            if ($urandom_range(9) == 0)
            begin
                wait_all_returned();
            end
        end
        wait_all_returned();
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.operation <= OP_INS_ORD;
        req_if.key_value <= '0;
        tx_idle_pct      = 20;
        rx_stall_pct     = 49;
        hold_off_request = 1'b0;
        items_sent       = 0;
        hold_offs_done   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty list, extremes, duplicates, misses and the unused codes.
        send_request(OP_DEL_FRONT, '0);
        send_request(OP_DEL_KEY, 32'sd5);
        send_request(OP_FIND, '0);
        send_request(OP_INS_ORD, '0);
        send_request(OP_INS_ORD, {1'b1, {(KEY_W-1){1'b0}}});
        send_request(OP_INS_ORD, {1'b0, {(KEY_W-1){1'b1}}});
        send_request(OP_INS_ORD, '0);
        send_request(OP_INS_ORD, -32'sd1);
        send_request(OP_INS_FRONT, 32'sd77);
        send_request(OP_INS_END, -32'sd7);
        send_request(OP_FIND, '0);
        send_request(OP_FIND, 32'sd123);
        send_request(OP_FIND, -32'sd7);
        send_request(OP_DEL_KEY, 32'sd123);
        send_request(OP_DEL_KEY, '0);
        send_request(OP_UNUSED_A, '1);
        send_request(OP_UNUSED_B, 32'sd9);
        send_request(OP_DEL_FRONT, '1);
        send_request(OP_DEL_KEY, {1'b0, {(KEY_W-1){1'b1}}});
        wait_all_returned();

        run_phase(20, 49, 1'b0);
        run_phase(49, 20, 1'b0);
        run_phase(0, 0, 1'b1);

        repeat (20) @(posedge clk);

        $display("Sent %0d request words, checked %0d response words, %0d long hold-off(s).",
                 items_sent, shadow.results_seen, hold_offs_done);
        $display("Statuses seen: ok %0d, not found %0d, full %0d, empty %0d.",
                 shadow.status_seen[ST_OK], shadow.status_seen[ST_NOT_FOUND],
                 shadow.status_seen[ST_FULL], shadow.status_seen[ST_EMPTY]);
        if (shadow.mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
